@@ hw/rtl/glef_pkg.sv @@
// ----------------------------------------------------------------------------
// glef_pkg
// Shared types and constants for the gray Laplacian / emboss filter: field
// widths, BT.709 gray weights, configuration register indexes, window types.
// ----------------------------------------------------------------------------
package glef_pkg;

  // Field and datapath widths
  localparam int GRAY_W = 8;
  localparam int LINE_W = 2 * GRAY_W;   // one line-store word: two rows of gray
  localparam int PROD_W = 24;           // weight * colour product, and their sum
  localparam int FW_W   = 11;           // frame_width register
  localparam int FH_W   = 12;           // frame_height register
  localparam int CFG_W  = 12;           // config write data (widest register)
  localparam int ROW_W  = 13;           // row counter runs up to height + 1
  localparam int SUM_W  = 12;           // signed kernel sums

  // Register reset values
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  // BT.709 luma weights in Q0.16, summing to 65536
  localparam logic [15:0] WEIGHT_RED   = 16'd13933;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

  localparam logic signed [SUM_W-1:0] BYTE_MAX = 12'sd255;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // 3x3 window of gray values: [row][column], row 0 on top, column 0 left
  typedef logic [2:0][2:0][GRAY_W-1:0] taps_t;

  // Per-item control decoded from the frame position
  typedef struct packed {
    logic edge_emit;   // row start: finish last pixel of the row before
    logic mid_emit;    // result for the pixel up and to the left
    logic top_zero;    // window row above the frame
    logic bot_zero;    // window row below the frame
    logic left_zero;   // window column left of the frame
    logic last;        // result is the last pixel of the frame
  } ctl_t;

endpackage

@@ hw/rtl/glef_line_ram.sv @@
// ----------------------------------------------------------------------------
// glef_line_ram
// Line store: one write and one read port, registered read data that holds
// while the read enable is low. A read of the address being written returns
// the old word.
// ----------------------------------------------------------------------------
module glef_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [glef_pkg::LINE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [glef_pkg::LINE_W-1:0] rdata
);
  import glef_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/glef_kernel.sv @@
// ----------------------------------------------------------------------------
// glef_kernel
// Applies the 4-neighbour Laplacian and the emboss kernel to a masked 3x3
// gray window and clamps both signed sums to 0..255.
// ----------------------------------------------------------------------------
module glef_kernel (
  input  glef_pkg::taps_t             taps,
  output logic [glef_pkg::GRAY_W-1:0] lap_pixel,
  output logic [glef_pkg::GRAY_W-1:0] emb_pixel
);
  import glef_pkg::*;

  logic signed [SUM_W-1:0] ext [3][3];
  logic signed [SUM_W-1:0] lap_sum;
  logic signed [SUM_W-1:0] emb_sum;

  function automatic logic [GRAY_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] v);
    logic [GRAY_W-1:0] res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (v > BYTE_MAX) begin
      res = '1;
    end else begin
      res = v[GRAY_W-1:0];
    end
    return res;
  endfunction

  // Widen taps, form both kernel sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ext[i][j] = $signed(SUM_W'(taps[i][j]));
      end
    end
    lap_sum = ext[0][1] + ext[1][0] + ext[1][2] + ext[2][1] - (ext[1][1] <<< 2);
    emb_sum = ext[1][1] + ext[1][2] + ext[2][1] + (ext[2][2] <<< 1)
            - (ext[0][0] <<< 1) - ext[0][1] - ext[1][0];
  end

  assign lap_pixel = clamp_byte(lap_sum);
  assign emb_pixel = clamp_byte(emb_sum);

endmodule

@@ hw/rtl/gray_laplacian_emboss_filter_core.sv @@
// ----------------------------------------------------------------------------
// gray_laplacian_emboss_filter_core
// Streaming RGB-to-gray conversion with 3x3 Laplacian and emboss filters.
// ----------------------------------------------------------------------------
// The core takes one RGB pixel per clock in raster order and sustains one
// item per cycle while the output is not stalled; the line store is a single
// memory read and written once per item, so it sets that rate. Each pixel's
// result is emitted when the item one row plus one pixel later is accepted,
// and reaches the outputs through the window stage and output register. Send
// flush items after the frame to drain the last row; frame_end marks the
// final pixel's result, after which the next item starts a new frame.
// Pixels outside the frame count as zero. A configuration write restarts
// the frame; write only while the core is idle.
// ----------------------------------------------------------------------------
module gray_laplacian_emboss_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  glef_pkg::cfg_index_t        cfg_index,
  input  logic [glef_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [glef_pkg::GRAY_W-1:0] red,
  input  logic [glef_pkg::GRAY_W-1:0] green,
  input  logic [glef_pkg::GRAY_W-1:0] blue,
  input  logic                        flush,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [glef_pkg::GRAY_W-1:0] laplacian_pixel,
  output logic [glef_pkg::GRAY_W-1:0] emboss_pixel,
  output logic                        frame_end
);
  import glef_pkg::*;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = COL_W + 1;
  localparam int WIDTH_RESET = (MAX_WIDTH < FRAME_WIDTH_RESET) ? MAX_WIDTH : FRAME_WIDTH_RESET;

  // Configuration, held as effective values
  logic [WID_W-1:0] width_eff;
  logic [FH_W-1:0]  height_eff;
  logic [ROW_W-1:0] height_ext;

  // Frame position
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [WID_W-1:0] col_p1;
  logic             row_end;
  logic             gray_en;
  ctl_t             ctl_in;
  logic             accept;

  // Stage 1: line-store data returns
  logic              s1_valid, s1_ready, s1_adv, s1_emit;
  logic [COL_W-1:0]  s1_col;
  ctl_t              s1_ctl;
  logic [PROD_W-1:0] s1_prod_r, s1_prod_g, s1_prod_b;
  logic              s1_fwd;
  logic [LINE_W-1:0] s1_fwd_line;
  logic              fwd;
  logic [LINE_W-1:0] line_rdata, line, line_wdata;
  logic [PROD_W-1:0] gray_sum;
  logic [GRAY_W-1:0] gray, up1, up2;
  logic [2:0][GRAY_W-1:0] col_new;
  logic [2:0][GRAY_W-1:0] win_a, win_b;
  taps_t             taps;

  // Stage 2: masked window
  logic              s2_valid, s2_ready, s2_adv;
  taps_t             s2_taps;
  logic              s2_last;
  logic [GRAY_W-1:0] lap_val, emb_val;
  logic              out_free;

  assign height_ext = ROW_W'(height_eff);

  // Configuration registers: clamp width, map zero height to one
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WID_W'(WIDTH_RESET);
      height_eff <= FH_W'(FRAME_HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          if (cfg_data[FW_W-1:0] == '0) begin
            width_eff <= WID_W'(1);
          end else if (32'(cfg_data[FW_W-1:0]) > 32'(MAX_WIDTH)) begin
            width_eff <= WID_W'(MAX_WIDTH);
          end else begin
            width_eff <= WID_W'(cfg_data[FW_W-1:0]);
          end
        end
        CFG_FRAME_HEIGHT: begin
          height_eff <= (cfg_data[FH_W-1:0] == '0) ? FH_W'(1) : cfg_data[FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Decode position: which result this beat releases, window masks, next position
  always_comb begin
    col_p1           = WID_W'(col) + WID_W'(1);
    row_end          = (col_p1 == width_eff);
    gray_en          = !flush && (row < height_ext);
    ctl_in.edge_emit = (col == '0) && (row >= ROW_W'(2));
    ctl_in.mid_emit  = (col != '0) && (row != '0);
    ctl_in.last      = ctl_in.edge_emit && (row == height_ext + ROW_W'(1));
    if (ctl_in.edge_emit) begin
      ctl_in.top_zero  = (row == ROW_W'(2));
      ctl_in.bot_zero  = (row > height_ext);
      ctl_in.left_zero = (width_eff == WID_W'(1));
    end else begin
      ctl_in.top_zero  = (row == ROW_W'(1));
      ctl_in.bot_zero  = (row >= height_ext);
      ctl_in.left_zero = (col == COL_W'(1));
    end
    if (ctl_in.last) begin
      col_next = '0;
      row_next = '0;
    end else if (row_end) begin
      col_next = '0;
      row_next = row + ROW_W'(1);
    end else begin
      col_next = col_p1[COL_W-1:0];
      row_next = row;
    end
  end

  // Position counters: restart on config write, advance per accepted beat
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Handshake across the stages
  assign out_free = !out_valid || out_ready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_ready = !s2_valid || out_free;
  assign s1_emit  = s1_ctl.edge_emit || s1_ctl.mid_emit;
  assign s1_adv   = s1_valid && (!s1_emit || s2_ready);
  assign s1_ready = !s1_valid || s1_adv;
  assign in_ready = s1_ready;
  assign accept   = in_valid && s1_ready;

  // Forward the word being written when the new beat reads the same entry
  assign fwd = s1_adv && (s1_col == col);

  // Stage 1 register: weighted colour products and read bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= col;
      s1_ctl      <= ctl_in;
      s1_prod_r   <= gray_en ? {16'd0, red} * PROD_W'(WEIGHT_RED) : '0;
      s1_prod_g   <= gray_en ? {16'd0, green} * PROD_W'(WEIGHT_GREEN) : '0;
      s1_prod_b   <= gray_en ? {16'd0, blue} * PROD_W'(WEIGHT_BLUE) : '0;
      s1_fwd      <= fwd;
      s1_fwd_line <= line_wdata;
    end
  end

  glef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (line_rdata)
  );

  // Gray value, line-store update word and window taps
  always_comb begin
    line       = s1_fwd ? s1_fwd_line : line_rdata;
    up2        = line[LINE_W-1:GRAY_W];
    up1        = line[GRAY_W-1:0];
    gray_sum   = s1_prod_r + s1_prod_g + s1_prod_b;
    gray       = gray_sum[PROD_W-1:PROD_W-GRAY_W];
    line_wdata = {up1, gray};
    col_new[0] = up2;
    col_new[1] = up1;
    col_new[2] = gray;
    for (int i = 0; i < 3; i++) begin
      taps[i][0] = s1_ctl.left_zero ? '0 : win_a[i];
      taps[i][1] = win_b[i];
      taps[i][2] = s1_ctl.edge_emit ? '0 : col_new[i];
    end
    if (s1_ctl.top_zero) begin
      taps[0] = '0;
    end
    if (s1_ctl.bot_zero) begin
      taps[2] = '0;
    end
  end

  // Shift the window one column per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
    end else if (s1_adv) begin
      win_a <= win_b;
      win_b <= col_new;
    end
  end

  // Stage 2 register: only beats that release a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_adv && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      s2_taps <= taps;
      s2_last <= s1_ctl.last;
    end
  end

  glef_kernel u_kernel (
    .taps      (s2_taps),
    .lap_pixel (lap_val),
    .emb_pixel (emb_val)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      laplacian_pixel <= lap_val;
      emboss_pixel    <= emb_val;
      frame_end       <= s2_last;
    end
  end

  // Column stays inside the frame width
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WID_W'(col) < width_eff)
    else $error("column counter beyond frame width");

  // Row never passes the drain row
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= height_ext + ROW_W'(1))
    else $error("row counter beyond drain row");

  // Frame end restarts the position
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && ctl_in.last |=> (col == '0) && (row == '0))
    else $error("position not cleared after frame end");

  // A stalled window beat holds its taps
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_free |=> s2_valid && $stable(s2_taps) && $stable(s2_last))
    else $error("stage 2 changed while stalled");

endmodule
